// ===== rtl/chs_pkg.sv =====
// Package for the chained hash set: sizes, operation and status codes,
// transaction payload types and the slot and address helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

  localparam int BUCKETS = 10;
  localparam int DEPTH   = 8;

  localparam int KEY_W    = 31;
  localparam int OP_W     = 3;
  localparam int BSEL_W   = 4;
  localparam int STATUS_W = 2;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(BUCKETS * DEPTH);

  // The hash folds the key in eight bits per step.
  localparam int HASH_BITS  = 8;
  localparam int HASH_STEPS = (KEY_W + HASH_BITS - 1) / HASH_BITS;
  localparam int HASH_PAD_W = HASH_STEPS * HASH_BITS;
  localparam int STEP_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [BSEL_W-1:0] bucket;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
  } rsp_t;

  // Slot of the entry at a given offset from the bucket's front.
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] h,
                                                  input logic [CNT_W-1:0]  o);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(o);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return SLOT_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] key_addr(input logic [BKT_W-1:0]  b,
                                                 input logic [SLOT_W-1:0] s);
    return ADDR_W'(int'(b) * DEPTH + int'(s));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/chained_hash_set.sv =====
// Flow: an unused code goes from idle straight to done, a removal passes through exec, and
// an insert passes through the 4-step mod hash and then exec; a lookup does the same and,
// if its bucket holds keys, scans the key memory one compare per cycle until a hit or the bucket's end.
// Throughput: one transaction at a time; a new one is taken in the cycle
// after the previous result is loaded into the output register.
// Reset (rst, synchronous): every bucket is empty with its head at slot 0. Uses chs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_set (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire chs_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output chs_pkg::rsp_t      out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;

  logic [chs_pkg::OP_W-1:0]       op;
  logic [chs_pkg::KEY_W-1:0]      key;
  logic [chs_pkg::HASH_PAD_W-1:0] key_sh;
  logic [chs_pkg::BKT_W-1:0]      rem, rem_next;
  logic [chs_pkg::STEP_W-1:0]     step;
  logic [chs_pkg::BKT_W-1:0]      bkt;
  logic                           bkt_ok;
  logic [chs_pkg::CNT_W-1:0]      off;
  logic [chs_pkg::STATUS_W-1:0]   res_status;
  logic                           res_found;

  logic [chs_pkg::SLOT_W-1:0] head  [chs_pkg::BUCKETS];
  logic [chs_pkg::CNT_W-1:0]  count [chs_pkg::BUCKETS];

  logic [chs_pkg::KEY_W-1:0]  mem [chs_pkg::BUCKETS * chs_pkg::DEPTH];
  logic [chs_pkg::KEY_W-1:0]  rd_data;
  logic [chs_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic                       mem_we;

  logic [chs_pkg::SLOT_W-1:0] hd, hd_front;
  logic [chs_pkg::CNT_W-1:0]  ct;
  logic                       is_ins, is_del, is_full, is_empty;
  logic                       accept, load_out;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  assign hd       = head[bkt];
  assign ct       = count[bkt];
  assign hd_front = (hd == '0) ? chs_pkg::SLOT_W'(chs_pkg::DEPTH - 1) : hd - 1'b1;
  assign is_ins   = (op == chs_pkg::OP_INS_FRONT) || (op == chs_pkg::OP_INS_BACK);
  assign is_del   = (op == chs_pkg::OP_DEL_FRONT) || (op == chs_pkg::OP_DEL_BACK);
  assign is_full  = (ct >= chs_pkg::CNT_W'(chs_pkg::DEPTH));
  assign is_empty = !bkt_ok || (ct == '0);

  // Eight restoring mod steps on the top byte of the shifted key.
  always_comb begin
    logic [chs_pkg::BKT_W:0] t;
    rem_next = rem;
    for (int i = 0; i < chs_pkg::HASH_BITS; i++) begin
      t = {rem_next, key_sh[chs_pkg::HASH_PAD_W-1-i]};
      if (t >= (chs_pkg::BKT_W+1)'(chs_pkg::BUCKETS)) begin
        t = t - (chs_pkg::BKT_W+1)'(chs_pkg::BUCKETS);
      end
      rem_next = t[chs_pkg::BKT_W-1:0];
    end
  end

  assign rd_addr = chs_pkg::key_addr(bkt, chs_pkg::slot_wrap(hd, off));
  assign wr_addr = (op == chs_pkg::OP_INS_FRONT) ? chs_pkg::key_addr(bkt, hd_front)
                                                 : chs_pkg::key_addr(bkt,
                                                     chs_pkg::slot_wrap(hd, ct));
  assign mem_we  = (state == S_EXEC) && is_ins && !is_full;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= key;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.operation)
            chs_pkg::OP_INS_FRONT, chs_pkg::OP_INS_BACK,
            chs_pkg::OP_LOOKUP:                           state_next = S_HASH;
            chs_pkg::OP_DEL_FRONT, chs_pkg::OP_DEL_BACK:  state_next = S_EXEC;
            default:                                      state_next = S_DONE;
          endcase
        end
      end
      S_HASH: begin
        if (step == chs_pkg::STEP_W'(chs_pkg::HASH_STEPS - 1)) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op == chs_pkg::OP_LOOKUP && ct != '0) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (rd_data == key || off == ct) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < chs_pkg::BUCKETS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_EXEC && is_ins && !is_full) begin
        if (op == chs_pkg::OP_INS_FRONT) begin
          head[bkt] <= hd_front;
        end
        count[bkt] <= ct + 1'b1;
      end
      if (state == S_EXEC && is_del && !is_empty) begin
        if (op == chs_pkg::OP_DEL_FRONT) begin
          head[bkt] <= chs_pkg::slot_wrap(hd, chs_pkg::CNT_W'(1));
        end
        count[bkt] <= ct - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op         <= in_data.operation;
        key        <= in_data.key;
        key_sh     <= chs_pkg::HASH_PAD_W'(in_data.key);
        rem        <= '0;
        step       <= '0;
        off        <= '0;
        res_status <= chs_pkg::ST_DONE;
        res_found  <= 1'b0;
        // A removal names its bucket; an index past the last bucket acts empty.
        if (32'(in_data.bucket) < chs_pkg::BUCKETS) begin
          bkt    <= chs_pkg::BKT_W'(32'(in_data.bucket));
          bkt_ok <= 1'b1;
        end else begin
          bkt    <= '0;
          bkt_ok <= 1'b0;
        end
      end
      S_HASH: begin
        rem    <= rem_next;
        key_sh <= key_sh << chs_pkg::HASH_BITS;
        step   <= step + 1'b1;
        if (step == chs_pkg::STEP_W'(chs_pkg::HASH_STEPS - 1)) begin
          bkt    <= rem_next;
          bkt_ok <= 1'b1;
        end
      end
      S_EXEC: begin
        off <= off + 1'b1;
        if (is_ins && is_full) begin
          res_status <= chs_pkg::ST_FULL;
        end
        if (is_del && is_empty) begin
          res_status <= chs_pkg::ST_EMPTY;
        end
      end
      S_SCAN: begin
        if (rd_data == key) begin
          res_found <= 1'b1;
        end else if (off != ct) begin
          off <= off + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.status <= res_status;
      out_data.found  <= res_found;
    end
  end

  // Every accepted transaction leaves the idle state.
  assert property (@(posedge clk) disable iff (rst) accept |=> state != S_IDLE)
    else $error("accepted transaction did not start");

  // Only lookups report a hit, and a hit never comes with a refusal.
  assert property (@(posedge clk) disable iff (rst)
    load_out && res_found |-> op == chs_pkg::OP_LOOKUP && res_status == chs_pkg::ST_DONE)
    else $error("found set outside a lookup");

  // The key memory is written only by an accepted insert into a bucket with room.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_EXEC && is_ins && ct < chs_pkg::CNT_W'(chs_pkg::DEPTH))
    else $error("key memory written outside an insert");

  // A bucket never holds more than DEPTH keys.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> ct <= chs_pkg::CNT_W'(chs_pkg::DEPTH))
    else $error("bucket count overflow");

  // The scan never runs past the live entries.
  assert property (@(posedge clk) disable iff (rst) state == S_SCAN |-> off <= ct)
    else $error("scan offset past bucket end");

endmodule

`default_nettype wire

// ===== dv/chs_checker.sv =====
// Checker for the chained hash set: watches both transaction channels, keeps its own
// copy of the bucket contents, predicts each reply and compares it. Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_checker
  import chs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  output int   errors,
  output int   outstanding
);

  logic [KEY_W-1:0] bucket_store [BUCKETS][DEPTH];
  int unsigned      front_slot [BUCKETS];
  int unsigned      fill [BUCKETS];
  rsp_t             reply_queue [$];

  // Applies one request to the shadow buckets and returns the reply it should get.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t        res;
    int unsigned b;
    res = '0;
    res.status = ST_DONE;
    case (r.operation)
      OP_INS_FRONT, OP_INS_BACK: begin
        b = r.key % BUCKETS;
        if (fill[b] >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (r.operation == OP_INS_FRONT) begin
            front_slot[b] = (front_slot[b] + DEPTH - 1) % DEPTH;
            bucket_store[b][front_slot[b]] = r.key;
          end else begin
            bucket_store[b][(front_slot[b] + fill[b]) % DEPTH] = r.key;
          end
          fill[b]++;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        b = r.bucket;
        if (b >= BUCKETS || fill[b] == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (r.operation == OP_DEL_FRONT) begin
            front_slot[b] = (front_slot[b] + 1) % DEPTH;
          end
          fill[b]--;
        end
      end
      OP_LOOKUP: begin
        b = r.key % BUCKETS;
        for (int unsigned i = 0; i < fill[b]; i++) begin
          if (bucket_store[b][(front_slot[b] + i) % DEPTH] == r.key) begin
            res.found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) begin
        front_slot[b] = 0;
        fill[b] = 0;
      end
      reply_queue.delete();
    end else begin
      // Replies are compared before the new request is queued; a reply can never
      // belong to a request accepted at the same edge.
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: unexpected reply status=%0d found=%0b", $time,
                   out_data.status, out_data.found);
          errors++;
        end else begin
          want = reply_queue.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_data.status);
            errors++;
          end
          if (out_data.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b", $time,
                     want.found, out_data.found);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        reply_queue.push_back(apply_request(in_data));
      end
    end
    outstanding = reply_queue.size();
  end

endmodule

// ===== dv/tb_chained_hash_set.sv =====
// Testbench top for the chained hash set: clock, reset, directed and random request
// streams under several idle and stall mixes, and the verdict. Uses chs_pkg and chs_checker.
`timescale 1ns / 1ps

module tb_chained_hash_set;
  import chs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  int errors;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int ins_weight;
  logic [KEY_W-1:0] recent_keys [16];
  int recent_ptr = 0;

  chained_hash_set u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  chs_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  function automatic req_t make_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                    input logic [BSEL_W-1:0] b);
    req_t r;
    r.operation = op;
    r.key = k;
    r.bucket = b;
    return r;
  endfunction

  // Mostly small keys so buckets fill and lookups hit; some reuse, some full-range.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) begin
      return KEY_W'($urandom_range(59));
    end else if (r < 75) begin
      return recent_keys[$urandom_range(15)];
    end
    return KEY_W'($urandom);
  endfunction

  function automatic req_t random_req();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r = make_req(OP_LOOKUP, pick_key(), BSEL_W'($urandom));
    if (pick < ins_weight) begin
      r.operation = $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
      recent_keys[recent_ptr] = r.key;
      recent_ptr = (recent_ptr + 1) % 16;
    end else if (pick < ins_weight + 30) begin
      r.operation = $urandom_range(1) ? OP_DEL_FRONT : OP_DEL_BACK;
      r.bucket = ($urandom_range(9) == 0) ? BSEL_W'($urandom_range(15, BUCKETS))
                                          : BSEL_W'($urandom_range(BUCKETS - 1));
    end else if (pick >= 96) begin
      r.operation = OP_W'($urandom_range(7, 5));
    end
    return r;
  endfunction

  task automatic send(input req_t r);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    req_t directed [$];
    for (int i = 0; i < 16; i++) begin
      recent_keys[i] = KEY_W'(i);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(make_req(OP_LOOKUP, '0, '0));
    directed.push_back(make_req(OP_INS_FRONT, '0, '1));
    directed.push_back(make_req(OP_INS_BACK, '1, '0));
    directed.push_back(make_req(OP_LOOKUP, '0, '1));
    directed.push_back(make_req(OP_LOOKUP, '1, '0));
    // Removal bucket indexes at and past the bucket count behave as empty buckets.
    directed.push_back(make_req(OP_DEL_FRONT, '1, 4'd15));
    directed.push_back(make_req(OP_DEL_BACK, '0, 4'(BUCKETS)));
    directed.push_back(make_req(OP_DEL_FRONT, 31'd123, 4'd3));
    directed.push_back(make_req(OP_W'(5), 31'd5, 4'd1));
    directed.push_back(make_req(OP_W'(6), '1, 4'd2));
    directed.push_back(make_req(OP_W'(7), 31'd25, 4'd5));
    // Fill bucket five from both ends, then push past its capacity.
    for (int i = 0; i < DEPTH; i++) begin
      directed.push_back(make_req((i % 2) ? OP_INS_BACK : OP_INS_FRONT,
                                  KEY_W'(5 + 10 * i), '0));
    end
    directed.push_back(make_req(OP_INS_FRONT, 31'd1005, '0));
    directed.push_back(make_req(OP_INS_BACK, 31'd2005, '0));
    directed.push_back(make_req(OP_DEL_FRONT, '0, 4'd5));
    directed.push_back(make_req(OP_DEL_BACK, '0, 4'd5));
    foreach (directed[i]) begin
      send(directed[i]);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        if (n % 40 == 0) begin
          ins_weight = $urandom_range(55, 15);
        end
        send(random_req());
      end
      // Let the block drain completely before the next mix starts.
      wait (outstanding == 0);
      @(negedge clk);
    end

    stall_pct = 0;
    wait (outstanding == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
